@@ rtl/mpt_pkg.sv @@
// ----------------------------------------------------------------------------
// mpt_pkg: shared constants for the modulus power transform
// Fixed-point formats, default widths and the reciprocal table used by the
// exponential series.
// ----------------------------------------------------------------------------
package mpt_pkg;

  // default sample width and fraction bits (Q16.16)
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // lambda register, signed Q4.12
  localparam int LAM_W  = 16;
  localparam int LAM_FB = 12;

  // log2 result fraction bits and lambda*log2 fraction bits
  localparam int LOG_FB = 24;
  localparam int T_FB   = LOG_FB + LAM_FB;

  // ln(2) in Q0.32 and one in Q1.30
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
  localparam logic [31:0] ONE30   = 32'h4000_0000;

  // number of terms in the exp() series
  localparam int HORNER_TERMS = 12;

  // floor(2^32 / n) for the series divisors
  function automatic logic [32:0] recip_q32(input int unsigned n);
    case (n)
      1:       return 33'h1_0000_0000;
      2:       return 33'h0_8000_0000;
      3:       return 33'h0_5555_5555;
      4:       return 33'h0_4000_0000;
      5:       return 33'h0_3333_3333;
      6:       return 33'h0_2AAA_AAAA;
      7:       return 33'h0_2492_4924;
      8:       return 33'h0_2000_0000;
      9:       return 33'h0_1C71_C71C;
      10:      return 33'h0_1999_9999;
      11:      return 33'h0_1745_D174;
      12:      return 33'h0_1555_5555;
      default: return 33'h0_0000_0000;
    endcase
  endfunction

endpackage

@@ rtl/modulus_power_transform_top.sv @@
// ----------------------------------------------------------------------------
// modulus_power_transform_top: pipelined modulus power transform
// sign(x)*ln(|x|+1) for lambda zero, else sign(x)*((|x|+1)^lambda - 1)/lambda,
// saturated to the sample range with an overflow flag.
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_sample_value
// out     | output    | out_valid / out_ready | out_transformed_value, out_overflow_flag
// cfg     | input     | cfg_valid / cfg_ready | cfg_exponent_lambda
//
// one transaction per cycle while the pipeline does not hold; the stages are:
// 3 front stages, 24 log2 squaring stages, 2 product stages, 36 series stages
// (12 terms of multiply, reciprocal multiply, correction), 2 numerator stages,
// DATA_WIDTH + 1 restoring divide stages and the output register.
// reset clears the valid bits and lambda; cfg_ready is always high.
// the whole pipeline holds while the output register is full and not taken.
// ----------------------------------------------------------------------------
module modulus_power_transform_top #(
  parameter int DATA_WIDTH = mpt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mpt_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [DATA_WIDTH-1:0]       in_sample_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [DATA_WIDTH-1:0]       out_transformed_value,
  output logic                               out_overflow_flag,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic signed [mpt_pkg::LAM_W-1:0]   cfg_exponent_lambda
);

  localparam int DW   = DATA_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int MW   = DW + 1;
  localparam int PW   = $clog2(DW + 1);
  localparam int LW   = PW + mpt_pkg::LOG_FB;
  localparam int TW   = LW + mpt_pkg::LAM_W + 1;
  localparam int KW   = TW - mpt_pkg::T_FB;
  localparam int SH   = mpt_pkg::LOG_FB + 32 - FB;
  localparam int LGW  = LW + 33;
  localparam int RLW  = LGW - SH;
  localparam int KMAX = DW - FB + 2;
  localparam int NW   = 32 + KMAX;
  localparam int DNW  = mpt_pkg::LAM_W + 30 - FB;
  localparam int NNW  = NW + mpt_pkg::LAM_FB + 1;
  localparam int RRW  = ((RLW > DW + 1) ? RLW : DW + 1) + 1;

  // stage map
  localparam int S_FRONT = 0;
  localparam int S_LZ    = 1;
  localparam int S_NORM  = 2;
  localparam int S_LOG0  = 3;
  localparam int S_MUL   = S_LOG0 + mpt_pkg::LOG_FB;
  localparam int S_EXP   = S_MUL + 1;
  localparam int S_HOR   = S_EXP + 1;
  localparam int S_NUM   = S_HOR + 3 * mpt_pkg::HORNER_TERMS;
  localparam int S_DPRE  = S_NUM + 1;
  localparam int S_DIV   = S_DPRE + 1;
  localparam int S_FIN   = S_DIV + DW + 1;
  localparam int NST     = S_FIN + 1;

  typedef struct packed {
    logic                             zero;
    logic                             neg;
    logic signed [mpt_pkg::LAM_W-1:0] lam;
    logic [MW-1:0]                    m;
    logic [PW-1:0]                    pos;
    logic [30:0]                      y;
    logic [LW-1:0]                    l;
    logic signed [TW-1:0]             t;
    logic [LW+31:0]                   lg;
    logic signed [KW-1:0]             k;
    logic [29:0]                      u;
    logic [RLW-1:0]                   rl;
    logic [31:0]                      s;
    logic [31:0]                      x;
    logic [31:0]                      qe;
    logic                             huge;
    logic [NW-1:0]                    num;
    logic                             big;
    logic [DNW-1:0]                   den;
    logic [DNW-1:0]                   rem;
    logic [DW:0]                      dq;
    logic [DW-1:0]                    res;
    logic                             ovf;
  } pipe_t;

  logic signed [mpt_pkg::LAM_W-1:0] lam_r;
  logic [DW-1:0]                    smp_u;
  logic                             pipe_en;
  logic                             vld_r   [NST];
  pipe_t                            pipe_r  [NST];
  pipe_t                            pipe_nxt[NST];

  assign smp_u     = in_sample_value;
  assign cfg_ready = 1'b1;

  // lambda register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lam_r <= '0;
    end else if (cfg_valid) begin
      lam_r <= cfg_exponent_lambda;
    end
  end

  // global advance: everything moves unless the output waits
  assign pipe_en  = !vld_r[S_FIN] || out_ready;
  assign in_ready = pipe_en;

  // stage logic
  for (genvar j = 0; j < NST; j++) begin : g_stage
    pipe_t src;
    pipe_t nxt;

    assign src         = (j == 0) ? '0 : pipe_r[(j == 0) ? 0 : j - 1];
    assign pipe_nxt[j] = nxt;

    if (j == S_FRONT) begin : g_front
      logic [DW-1:0] mag;
      // magnitude and m = |x| + 1
      always_comb begin
        nxt      = src;
        mag      = smp_u[DW-1] ? (~smp_u + 1'b1) : smp_u;
        nxt.zero = (smp_u == '0);
        nxt.neg  = smp_u[DW-1];
        nxt.m    = MW'(mag) + (MW'(1) << FB);
        nxt.lam  = lam_r;
      end
    end else if (j == S_LZ) begin : g_lz
      // leading one position
      always_comb begin
        nxt     = src;
        nxt.pos = '0;
        for (int b = 0; b < MW; b++) begin
          if (src.m[b]) begin
            nxt.pos = PW'(b);
          end
        end
      end
    end else if (j == S_NORM) begin : g_norm
      logic [MW+29:0] wide;
      // mantissa to Q1.30, integer part of log2
      always_comb begin
        nxt   = src;
        wide  = {src.m, 30'b0} >> src.pos;
        nxt.y = wide[30:0];
        nxt.l = {src.pos - PW'(FB), {mpt_pkg::LOG_FB{1'b0}}};
      end
    end else if (j >= S_LOG0 && j < S_MUL) begin : g_log
      localparam int BI = mpt_pkg::LOG_FB - 1 - (j - S_LOG0);
      logic [61:0] sq;
      // one fraction bit of log2 per squaring
      always_comb begin
        nxt = src;
        sq  = src.y * src.y;
        if (sq[61]) begin
          nxt.y     = sq[61:31];
          nxt.l[BI] = 1'b1;
        end else begin
          nxt.y = sq[60:30];
        end
      end
    end else if (j == S_MUL) begin : g_mul
      // lambda*log2(m) and log2(m)*ln2
      always_comb begin
        nxt    = src;
        nxt.t  = src.lam * $signed({1'b0, src.l});
        nxt.lg = src.l * mpt_pkg::LN2_Q32;
      end
    end else if (j == S_EXP) begin : g_exp
      logic [61:0]    fu;
      logic [LGW-1:0] lgh;
      // split exponent, scale fraction by ln2, round log form
      always_comb begin
        nxt    = src;
        fu     = src.t[mpt_pkg::T_FB-1:mpt_pkg::T_FB-30] * mpt_pkg::LN2_Q32;
        nxt.u  = fu[61:32];
        nxt.k  = src.t[TW-1:mpt_pkg::T_FB];
        nxt.s  = mpt_pkg::ONE30;
        lgh    = {1'b0, src.lg} + (LGW'(1) << (SH - 1));
        nxt.rl = lgh[LGW-1:SH];
      end
    end else if (j >= S_HOR && j < S_NUM) begin : g_hor
      localparam int HS = (j - S_HOR) / 3;
      localparam int PH = (j - S_HOR) % 3;
      localparam int NT = mpt_pkg::HORNER_TERMS - HS;
      if (PH == 0) begin : g_ph0
        logic [61:0] pr;
        // u * s
        always_comb begin
          nxt   = src;
          pr    = src.u * src.s;
          nxt.x = pr[61:30];
        end
      end else if (PH == 1) begin : g_ph1
        logic [64:0] pq;
        // quotient estimate by reciprocal
        always_comb begin
          nxt    = src;
          pq     = src.x * mpt_pkg::recip_q32(NT);
          nxt.qe = pq[63:32];
        end
      end else begin : g_ph2
        logic [35:0] pn;
        logic [35:0] rr;
        logic [31:0] q;
        // correct quotient, next partial sum
        always_comb begin
          nxt = src;
          pn  = src.qe * 4'(NT);
          rr  = {4'b0, src.x} - pn;
          q   = (rr >= 36'(NT)) ? src.qe + 32'd1 : src.qe;
          nxt.s = mpt_pkg::ONE30 + q;
        end
      end
    end else if (j == S_NUM) begin : g_num
      logic [KW-1:0] kk;
      logic [KW-1:0] kn;
      logic [NW-1:0] up;
      logic [31:0]   pw;
      // |2^k * e - 1| in Q.30
      always_comb begin
        nxt      = src;
        kk       = src.k;
        kn       = ~kk + 1'b1;
        up       = NW'(src.s) << kk;
        pw       = src.s >> kn;
        nxt.huge = (src.k > $signed(KW'(KMAX)));
        if (!kk[KW-1]) begin
          nxt.num = up - NW'(mpt_pkg::ONE30);
        end else begin
          nxt.num = (pw >= mpt_pkg::ONE30) ? '0 : NW'(mpt_pkg::ONE30 - pw);
        end
      end
    end else if (j == S_DPRE) begin : g_dpre
      logic [mpt_pkg::LAM_W-1:0] alam;
      logic [DNW-1:0]            den;
      logic [NNW-1:0]            nn;
      logic [NNW-1:0]            hi;
      // rounded dividend, divisor, range check on the quotient
      always_comb begin
        nxt     = src;
        alam    = src.lam[mpt_pkg::LAM_W-1] ? (~src.lam + 1'b1) : src.lam;
        den     = DNW'(alam) << (30 - FB);
        nn      = (NNW'(src.num) << mpt_pkg::LAM_FB) + NNW'(den >> 1);
        hi      = nn >> (DW + 1);
        nxt.den = den;
        nxt.big = (hi >= NNW'(den));
        nxt.rem = hi[DNW-1:0];
        nxt.dq  = nn[DW:0];
      end
    end else if (j >= S_DIV && j < S_FIN) begin : g_div
      logic [DNW:0] r2;
      logic         qb;
      // one restoring divide step
      always_comb begin
        nxt = src;
        r2  = {src.rem, src.dq[DW]};
        qb  = (r2 >= {1'b0, src.den});
        if (qb) begin
          nxt.rem = DNW'(r2 - {1'b0, src.den});
        end else begin
          nxt.rem = r2[DNW-1:0];
        end
        nxt.dq = {src.dq[DW-1:0], qb};
      end
    end else begin : g_fin
      logic [RRW-1:0] r;
      logic [RRW-1:0] lim;
      logic           sat;
      logic           pwr;
      // select form, saturate, apply sign
      always_comb begin
        nxt = src;
        pwr = (src.lam != '0);
        r   = pwr ? RRW'(src.dq) : RRW'(src.rl);
        lim = src.neg ? (RRW'(1) << (DW - 1)) : ((RRW'(1) << (DW - 1)) - RRW'(1));
        sat = (pwr && (src.huge || src.big)) || (r > lim);
        if (sat) begin
          r = lim;
        end
        nxt.res = src.neg ? (~r[DW-1:0] + 1'b1) : r[DW-1:0];
        nxt.ovf = sat;
        if (src.zero) begin
          nxt.res = '0;
          nxt.ovf = 1'b0;
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NST; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else if (pipe_en) begin
      vld_r[0] <= in_valid;
      for (int j = 1; j < NST; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int j = 0; j < NST; j++) begin
        pipe_r[j] <= pipe_nxt[j];
      end
    end
  end

  assign out_valid             = vld_r[S_FIN];
  assign out_transformed_value = pipe_r[S_FIN].res;
  assign out_overflow_flag     = pipe_r[S_FIN].ovf;

endmodule

@@ tb/sv/mpt_checker.sv @@
// ----------------------------------------------------------------------------
// mpt_checker: transform predictor and result scoreboard
// Watches the sample, result and lambda channels, predicts each transformed
// value with its own fixed-point model and compares results in order.
// ----------------------------------------------------------------------------
module mpt_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_sample_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_transformed_value,
  input  logic               out_overflow_flag,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic signed [15:0] cfg_exponent_lambda,
  output int                 fail_count,
  output int                 pending_count
);

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic [31:0] value;
    logic        flag;
  } transform_t;

  transform_t       expected_results[$];
  logic      [15:0] lambda_copy;

  // fixed-point modulus transform of one sample
  function automatic transform_t predict_transform(input logic [31:0] x,
                                                   input logic [15:0] lam_bits);
    longint unsigned mag, m, y, lg, r, lim, ut, frac, e, num, den, pw, u, s, alam;
    longint          t, k, lam;
    int              p, i, n;
    bit              neg, sat;
    transform_t      res;
    neg = x[31];
    sat = 0;
    r   = 0;
    if (x == 32'd0) begin
      res.value = '0;
      res.flag  = 1'b0;
      return res;
    end
    mag = neg ? {32'd0, 32'd0 - x} : {32'd0, x};
    m   = mag + (64'd1 << 16);
    // log2 in Q.24: leading one then squaring of the Q1.30 mantissa
    p = 63;
    while (p > 0 && m[p] == 1'b0) p--;
    y  = (p > 30) ? (m >> (p - 30)) : (m << (30 - p));
    lg = longint'(p - 16) << 24;
    for (i = 23; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (ONE_Q30 << 1)) begin
        lg = lg | (64'd1 << i);
        y  = y >> 1;
      end
    end
    lam = longint'($signed(lam_bits));
    if (lam == 0) begin
      r = (lg * 64'hB17217F8 + (64'd1 << 39)) >> 40;
    end else begin
      t    = lam * longint'(lg);
      ut   = t;
      frac = ut & ((64'd1 << 36) - 1);
      if (t >= 0) k = longint'(ut >> 36);
      else k = -longint'((~ut) >> 36) - 1;
      // exp of the fractional part by a truncated series
      u = ((frac >> 6) * 64'hB17217F8) >> 32;
      s = ONE_Q30;
      for (n = 12; n >= 1; n--) s = ONE_Q30 + ((u * s) >> 30) / longint'(n);
      e    = s;
      alam = (lam < 0) ? -lam : lam;
      if (k > 18) begin
        sat = 1;
      end else begin
        if (k >= 0) begin
          num = (e << k) - ONE_Q30;
        end else begin
          pw  = (k <= -63) ? 64'd0 : (e >> (-k));
          num = (pw >= ONE_Q30) ? 64'd0 : ONE_Q30 - pw;
        end
        den = alam << 14;
        r   = ((num << 12) + den / 2) / den;
      end
    end
    lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
    if (sat || r > lim) begin
      r   = lim;
      sat = 1;
    end
    res.value = neg ? (32'd0 - r[31:0]) : r[31:0];
    res.flag  = sat;
    return res;
  endfunction

  assign pending_count = expected_results.size();

  // track lambda, queue predictions, check results
  always @(posedge clk) begin
    transform_t want;
    if (!rst_n) begin
      lambda_copy <= '0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) lambda_copy <= cfg_exponent_lambda;
      if (in_valid && in_ready)
        expected_results.push_back(predict_transform(in_sample_value, lambda_copy));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction value %h flag %b", $time,
                   out_transformed_value, out_overflow_flag);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.value !== out_transformed_value || want.flag !== out_overflow_flag) begin
            $display("%0t: mismatch expected value %h flag %b, actual value %h flag %b",
                     $time, want.value, want.flag, out_transformed_value,
                     out_overflow_flag);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_modulus_power_transform_top.sv @@
// ----------------------------------------------------------------------------
// tb_modulus_power_transform_top: stimulus and verdict for the transform
// Steps lambda through its extremes and typical values, sends directed and
// random samples with random gaps and back-pressure, and reports the result.
// ----------------------------------------------------------------------------
module tb_modulus_power_transform_top;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_sample_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_transformed_value;
  logic               out_overflow_flag;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic signed [15:0] cfg_exponent_lambda = '0;
  int                 fail_count;
  int                 pending_count;
  bit                 no_idle = 1'b0;

  always #4 clk = ~clk;

  modulus_power_transform_top i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_sample_value       (in_sample_value),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_transformed_value (out_transformed_value),
    .out_overflow_flag     (out_overflow_flag),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_exponent_lambda   (cfg_exponent_lambda)
  );

  mpt_checker i_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_sample_value       (in_sample_value),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_transformed_value (out_transformed_value),
    .out_overflow_flag     (out_overflow_flag),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_exponent_lambda   (cfg_exponent_lambda),
    .fail_count            (fail_count),
    .pending_count         (pending_count)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 18);
  end

  // one sample transaction, with a random gap before it unless no_idle is set
  task automatic send_sample(input logic [31:0] x);
    while (!no_idle && $urandom_range(0, 99) < 18) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_sample_value = x;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // lambda write while the pipeline is empty
  task automatic write_lambda(input logic [15:0] lam);
    while (pending_count != 0) @(negedge clk);
    cfg_valid           = 1'b1;
    cfg_exponent_lambda = lam;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] random_sample();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 32'h3FFFF);
      2:       v = 32'd0 - $urandom_range(0, 32'h3FFFF);
      3:       v = {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      4:       v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                        : 32'h8000_0000 + $urandom_range(0, 3);
      default: v = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 8));
    endcase
    return v;
  endfunction

  logic [31:0] directed_samples[20] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h8000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000,
    32'h0002_0000, 32'h00FF_FFFF, 32'hFF00_0000, 32'h5555_5555, 32'hAAAA_AAAA,
    32'h0000_FFFF, 32'h4000_0000, 32'hC000_0000, 32'h0010_0000, 32'hFFF0_0000
  };

  logic [15:0] lambda_steps[10];

  // stimulus and verdict
  initial begin
    lambda_steps = '{16'h0000, 16'h1000, 16'hF000, 16'h7FFF, 16'h8000,
                     16'h0001, 16'hFFFF, 16'h2000, 16'($urandom), 16'($urandom)};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (lambda_steps[ph]) begin
      write_lambda(lambda_steps[ph]);
      no_idle = (ph == 3);
      if (ph < 3) foreach (directed_samples[j]) send_sample(directed_samples[j]);
      for (int j = 0; j < 160; j++) begin
        // let the pipeline drain once mid-phase
        if (ph == 5 && j == 80) while (pending_count != 0) @(negedge clk);
        send_sample(random_sample());
      end
    end
    no_idle = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (120) @(posedge clk);
    if (fail_count == 0) $display("** modulus_power_transform_top: PASSED **");
    else $display("** modulus_power_transform_top: FAILED **");
    $finish;
  end

  // watchdog
  initial begin
    #3200000;
    $display("** modulus_power_transform_top: FAILED **");
    $finish;
  end

endmodule
